// File: src/ngll_pkg.sv
// ----------------------------------------------------------------------------
// ngll_pkg
// Shared types and constants of the GLL position parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ngll_pkg;

   localparam int FRAC_DIGITS_DEFAULT = 5;
   localparam int FRAC_KEPT_MAX       = 5;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_L      = 8'h4C;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_W      = 8'h57;

   localparam logic [2:0] HDR_IDLE = 3'd0;
   localparam logic [2:0] HDR_BODY = 3'd7;

   localparam logic [14:0] INT_SAT      = 15'd32767;
   localparam logic [8:0]  INT_SAT_DEG  = 9'd327;
   localparam logic [3:0]  INT_SAT_TENS = 4'd6;
   localparam logic [3:0]  INT_SAT_ONES = 4'd7;

   localparam logic [8:0]  LAT_MAX_DEG = 9'd90;
   localparam logic [8:0]  LON_MAX_DEG = 9'd180;
   localparam logic [6:0]  MINUTES_LIMIT = 7'd60;
   localparam logic [23:0] MIN_E5_MAX  = 24'd5999999;
   localparam logic [23:0] MIN_E5_UNIT = 24'd100000;

   typedef enum logic [1:0] {
      FIELD_LAT = 2'd0,
      FIELD_NS  = 2'd1,
      FIELD_LON = 2'd2,
      FIELD_EW  = 2'd3
   } field_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } stage_type;

   typedef struct packed {
      logic [6:0]  lat_degrees;
      logic [22:0] lat_minutes_e5;
      logic        lat_south;
      logic [7:0]  lon_degrees;
      logic [22:0] lon_minutes_e5;
      logic        lon_west;
      logic        well_formed;
   } result_type;

   typedef struct packed {
      logic valid;
      logic hold;
   } out_status_type;

endpackage

`default_nettype wire

// File: src/nmea_gll_position_parser.sv
// ----------------------------------------------------------------------------
// nmea_gll_position_parser
// Parses GLL sentences from a byte stream into one position per sentence.
//
//   channel   dir   payload                              beat
//   req_      in    rx_byte                              one character
//   rsp_      out   lat/lon degrees, minutes e5, flags   one position
//
// One byte per cycle sustained while no stalled result holds the flow; a byte
// is registered in the input register, and its position, if any, is then
// registered in the result register.
// Reset clears all parse state; the parser then waits for a dollar sign.
// A stalled result stops only a byte that would make a new result.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gll_position_parser #(
   parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_lat_degrees,
   output logic [22:0]      rsp_lat_minutes_e5,
   output logic             rsp_lat_south,
   output logic [7:0]       rsp_lon_degrees,
   output logic [22:0]      rsp_lon_minutes_e5,
   output logic             rsp_lon_west,
   output logic             rsp_well_formed
);

   ngll_pkg::stage_type      stage;
   ngll_pkg::result_type     result;
   ngll_pkg::result_type     rsp_data;
   ngll_pkg::out_status_type out_status;
   logic                     has_result;
   logic                     advance;
   logic                     load;

   assign advance = stage.valid && (!has_result || !out_status.hold);
   assign load    = advance && has_result;

   ngll_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .stage       (stage)
   );

   ngll_core #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   ngll_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .status    (out_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_lat_degrees    = rsp_data.lat_degrees;
   assign rsp_lat_minutes_e5 = rsp_data.lat_minutes_e5;
   assign rsp_lat_south      = rsp_data.lat_south;
   assign rsp_lon_degrees    = rsp_data.lon_degrees;
   assign rsp_lon_minutes_e5 = rsp_data.lon_minutes_e5;
   assign rsp_lon_west       = rsp_data.lon_west;
   assign rsp_well_formed    = rsp_data.well_formed;

   // an empty input register never pushes back
   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |-> !req_stall)
      else $error("input stalled with no byte held");

   // a new position never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(out_status.valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // a position with no flagged error is always in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_well_formed) |->
         (rsp_lat_degrees <= 7'd90) && (rsp_lon_degrees <= 8'd180) &&
         (rsp_lat_minutes_e5 < 23'd6000000) && (rsp_lon_minutes_e5 < 23'd6000000))
      else $error("well formed position out of range");

   // the result register is only loaded by a byte that is being consumed
   a_load_advances: assert property (@(posedge clock) disable iff (reset)
      load |-> stage.valid && !req_stall)
      else $error("result loaded without consuming a byte");

endmodule

`default_nettype wire

// File: src/ngll_in_reg.sv
// ----------------------------------------------------------------------------
// ngll_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ngll_in_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                advance,
   output ngll_pkg::stage_type      stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

`default_nettype wire

// File: src/ngll_core.sv
// ----------------------------------------------------------------------------
// ngll_core
// Header match, field parser and position formatting, one byte per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module ngll_core #(
   parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ngll_pkg::stage_type stage,
   input  wire logic                advance,
   output logic                     has_result,
   output ngll_pkg::result_type     result
);

   localparam logic [2:0] KEPT_DIGITS = 3'((FRAC_DIGITS < ngll_pkg::FRAC_KEPT_MAX) ?
                                           FRAC_DIGITS : ngll_pkg::FRAC_KEPT_MAX);

   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] c;
      c = ngll_pkg::CHAR_COMMA;
      unique case (pos)
         3'd1:    c = ngll_pkg::CHAR_G;
         3'd2:    c = ngll_pkg::CHAR_P;
         3'd3:    c = ngll_pkg::CHAR_G;
         3'd4:    c = ngll_pkg::CHAR_L;
         3'd5:    c = ngll_pkg::CHAR_L;
         default: c = ngll_pkg::CHAR_COMMA;
      endcase
      return c;
   endfunction

   function automatic logic [16:0] frac_scale(input logic [2:0] cnt);
      logic [16:0] s;
      s = 17'd1;
      unique case (cnt)
         3'd0:    s = 17'd100000;
         3'd1:    s = 17'd10000;
         3'd2:    s = 17'd1000;
         3'd3:    s = 17'd100;
         3'd4:    s = 17'd10;
         default: s = 17'd1;
      endcase
      return s;
   endfunction

   function automatic logic value_ok(input logic [8:0] deg, input logic [6:0] mm,
                                     input logic [16:0] f5, input logic [8:0] max_deg);
      logic ok;
      ok = (mm < ngll_pkg::MINUTES_LIMIT) &&
           ((deg < max_deg) || ((deg == max_deg) && (mm == 7'd0) && (f5 == 17'd0)));
      return ok;
   endfunction

   function automatic logic [22:0] minutes_e5(input logic [6:0] mm, input logic [16:0] f5);
      logic [23:0] m;
      m = 24'(mm) * ngll_pkg::MIN_E5_UNIT + 24'(f5);
      if (m > ngll_pkg::MIN_E5_MAX) begin
         m = ngll_pkg::MIN_E5_MAX;
      end
      return m[22:0];
   endfunction

   // parse state
   logic [2:0]          hdr_ff, hdr_in;
   ngll_pkg::field_type field_ff, field_in;
   logic [14:0]         ip_ff, ip_in;
   logic [8:0]          deg_ff, deg_in;
   logic [3:0]          tens_ff, tens_in;
   logic [3:0]          ones_ff, ones_in;
   logic [16:0]         frac_ff, frac_in;
   logic [2:0]          fcnt_ff, fcnt_in;
   logic                point_ff, point_in;
   logic [8:0]          lat_deg_ff, lat_deg_in;
   logic [6:0]          lat_mm_ff, lat_mm_in;
   logic [16:0]         lat_frac_ff, lat_frac_in;
   logic                south_ff, south_in;
   logic                err_ff, err_in;

   logic [7:0]  b;
   logic        is_digit;
   logic [3:0]  digit;
   logic [18:0] ip_next;
   logic [12:0] deg_next;
   logic [6:0]  mm;
   logic [33:0] f5_wide;
   logic [16:0] f5;
   logic        num_byte;
   logic        clear_num;
   logic        clear_all;

   assign b        = stage.rx_byte;
   assign is_digit = (b >= ngll_pkg::CHAR_ZERO) && (b <= ngll_pkg::CHAR_NINE);
   assign digit    = 4'(b - ngll_pkg::CHAR_ZERO);
   assign ip_next  = 19'(ip_ff) * 19'd10 + 19'(digit);
   assign deg_next = 13'(deg_ff) * 13'd10 + 13'(tens_ff);
   assign mm       = 7'(tens_ff) * 7'd10 + 7'(ones_ff);
   assign f5_wide  = 34'(frac_ff) * 34'(frac_scale(fcnt_ff));
   assign f5       = f5_wide[16:0];

   assign has_result = (b == ngll_pkg::CHAR_E || b == ngll_pkg::CHAR_W) &&
                       (hdr_ff == ngll_pkg::HDR_BODY) && (field_ff == ngll_pkg::FIELD_EW);

   always_comb begin
      hdr_in      = hdr_ff;
      field_in    = field_ff;
      ip_in       = ip_ff;
      deg_in      = deg_ff;
      tens_in     = tens_ff;
      ones_in     = ones_ff;
      frac_in     = frac_ff;
      fcnt_in     = fcnt_ff;
      point_in    = point_ff;
      lat_deg_in  = lat_deg_ff;
      lat_mm_in   = lat_mm_ff;
      lat_frac_in = lat_frac_ff;
      south_in    = south_ff;
      err_in      = err_ff;
      num_byte    = 1'b0;
      clear_num   = 1'b0;
      clear_all   = 1'b0;

      priority if (b == ngll_pkg::CHAR_DOLLAR) begin
         clear_all = 1'b1;
         hdr_in    = 3'd1;
      end else if (hdr_ff == ngll_pkg::HDR_IDLE) begin
         hdr_in = ngll_pkg::HDR_IDLE;
      end else if (hdr_ff != ngll_pkg::HDR_BODY) begin
         hdr_in = (b == hdr_char(hdr_ff)) ? hdr_ff + 3'd1 : ngll_pkg::HDR_IDLE;
      end else begin
         unique case (field_ff)
            ngll_pkg::FIELD_LAT: begin
               if (b == ngll_pkg::CHAR_COMMA) begin
                  if (!value_ok(deg_ff, mm, f5, ngll_pkg::LAT_MAX_DEG)) begin
                     err_in = 1'b1;
                  end
                  lat_deg_in  = deg_ff;
                  lat_mm_in   = mm;
                  lat_frac_in = f5;
                  clear_num   = 1'b1;
                  field_in    = ngll_pkg::FIELD_NS;
               end else begin
                  num_byte = 1'b1;
               end
            end
            ngll_pkg::FIELD_NS: begin
               // point flag doubles as "letter seen" here
               if (b == ngll_pkg::CHAR_N || b == ngll_pkg::CHAR_S) begin
                  if (point_ff) begin
                     err_in = 1'b1;
                  end
                  point_in = 1'b1;
                  south_in = (b == ngll_pkg::CHAR_S);
               end else if (b == ngll_pkg::CHAR_COMMA) begin
                  if (!point_ff) begin
                     err_in = 1'b1;
                  end
                  point_in = 1'b0;
                  field_in = ngll_pkg::FIELD_LON;
               end else begin
                  err_in = 1'b1;
               end
            end
            ngll_pkg::FIELD_LON: begin
               if (b == ngll_pkg::CHAR_COMMA) begin
                  if (!value_ok(deg_ff, mm, f5, ngll_pkg::LON_MAX_DEG)) begin
                     err_in = 1'b1;
                  end
                  field_in = ngll_pkg::FIELD_EW;
               end else begin
                  num_byte = 1'b1;
               end
            end
            ngll_pkg::FIELD_EW: begin
               if (has_result || b == ngll_pkg::CHAR_COMMA) begin
                  clear_all = 1'b1;
                  hdr_in    = ngll_pkg::HDR_IDLE;
               end else begin
                  err_in = 1'b1;
               end
            end
         endcase
      end

      if (num_byte) begin
         if (is_digit) begin
            if (!point_ff) begin
               if (ip_next > 19'(ngll_pkg::INT_SAT)) begin
                  ip_in   = ngll_pkg::INT_SAT;
                  deg_in  = ngll_pkg::INT_SAT_DEG;
                  tens_in = ngll_pkg::INT_SAT_TENS;
                  ones_in = ngll_pkg::INT_SAT_ONES;
                  err_in  = 1'b1;
               end else begin
                  ip_in   = ip_next[14:0];
                  deg_in  = deg_next[8:0];
                  tens_in = ones_ff;
                  ones_in = digit;
               end
            end else if (fcnt_ff < KEPT_DIGITS) begin
               // extra fraction digits are dropped silently
               frac_in = 17'(frac_ff * 17'd10 + 17'(digit));
               fcnt_in = fcnt_ff + 3'd1;
            end
         end else if (b == ngll_pkg::CHAR_POINT) begin
            if (point_ff) begin
               err_in = 1'b1;
            end
            point_in = 1'b1;
         end else begin
            err_in = 1'b1;
         end
      end

      if (clear_num || clear_all) begin
         ip_in    = '0;
         deg_in   = '0;
         tens_in  = '0;
         ones_in  = '0;
         frac_in  = '0;
         fcnt_in  = '0;
         point_in = 1'b0;
      end
      if (clear_all) begin
         field_in    = ngll_pkg::FIELD_LAT;
         lat_deg_in  = '0;
         lat_mm_in   = '0;
         lat_frac_in = '0;
         south_in    = 1'b0;
         err_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff      <= ngll_pkg::HDR_IDLE;
         field_ff    <= ngll_pkg::FIELD_LAT;
         ip_ff       <= '0;
         deg_ff      <= '0;
         tens_ff     <= '0;
         ones_ff     <= '0;
         frac_ff     <= '0;
         fcnt_ff     <= '0;
         point_ff    <= 1'b0;
         lat_deg_ff  <= '0;
         lat_mm_ff   <= '0;
         lat_frac_ff <= '0;
         south_ff    <= 1'b0;
         err_ff      <= 1'b0;
      end else if (advance) begin
         hdr_ff      <= hdr_in;
         field_ff    <= field_in;
         ip_ff       <= ip_in;
         deg_ff      <= deg_in;
         tens_ff     <= tens_in;
         ones_ff     <= ones_in;
         frac_ff     <= frac_in;
         fcnt_ff     <= fcnt_in;
         point_ff    <= point_in;
         lat_deg_ff  <= lat_deg_in;
         lat_mm_ff   <= lat_mm_in;
         lat_frac_ff <= lat_frac_in;
         south_ff    <= south_in;
         err_ff      <= err_in;
      end
   end

   always_comb begin
      result.lat_degrees    = (lat_deg_ff > ngll_pkg::LAT_MAX_DEG) ?
                              ngll_pkg::LAT_MAX_DEG[6:0] : lat_deg_ff[6:0];
      result.lat_minutes_e5 = minutes_e5(lat_mm_ff, lat_frac_ff);
      result.lat_south      = south_ff;
      result.lon_degrees    = (deg_ff > ngll_pkg::LON_MAX_DEG) ?
                              ngll_pkg::LON_MAX_DEG[7:0] : deg_ff[7:0];
      result.lon_minutes_e5 = minutes_e5(mm, f5);
      result.lon_west       = (b == ngll_pkg::CHAR_W);
      result.well_formed    = !err_ff;
   end

endmodule

`default_nettype wire

// File: src/ngll_out_reg.sv
// ----------------------------------------------------------------------------
// ngll_out_reg
// Result register: holds one position until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ngll_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire ngll_pkg::result_type result,
   output ngll_pkg::out_status_type  status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ngll_pkg::result_type      rsp_data
);

   logic                 valid_ff, valid_in;
   ngll_pkg::result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign status.valid = valid_ff;
   assign status.hold  = valid_ff && rsp_stall;
   assign rsp_valid    = valid_ff;
   assign rsp_data     = data_ff;

endmodule

`default_nettype wire

// File: tb/sv/nmea_gll_position_parser_tb.sv
// ----------------------------------------------------------------------------
// nmea_gll_position_parser_tb
// Feeds GLL sentences, broken sentences and line noise into the parser one
// character per beat, tracks the parse in a local model, and checks every
// position the block returns field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module nmea_gll_position_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ngll_pkg::*;

   localparam int KEPT_DIGITS = (FRAC_DIGITS_DEFAULT < FRAC_KEPT_MAX) ?
                                FRAC_DIGITS_DEFAULT : FRAC_KEPT_MAX;
   localparam logic [47:0] GLL_TAIL = {CHAR_G, CHAR_P, CHAR_G, CHAR_L, CHAR_L, CHAR_COMMA};
   localparam int IDLE_LIMIT = 2000;
   localparam int STIM_BYTES = 1350;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [6:0]  rsp_lat_degrees;
   logic [22:0] rsp_lat_minutes_e5;
   logic        rsp_lat_south;
   logic [7:0]  rsp_lon_degrees;
   logic [22:0] rsp_lon_minutes_e5;
   logic        rsp_lon_west;
   logic        rsp_well_formed;

   nmea_gll_position_parser #(.FRAC_DIGITS(FRAC_DIGITS_DEFAULT)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lat_degrees    (rsp_lat_degrees),
      .rsp_lat_minutes_e5 (rsp_lat_minutes_e5),
      .rsp_lat_south      (rsp_lat_south),
      .rsp_lon_degrees    (rsp_lon_degrees),
      .rsp_lon_minutes_e5 (rsp_lon_minutes_e5),
      .rsp_lon_west       (rsp_lon_west),
      .rsp_well_formed    (rsp_well_formed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // parse tracking
   // ------------------------------------------------------------------------
   logic [2:0]  hdr_pos    = HDR_IDLE;
   field_type   fld        = FIELD_LAT;
   logic [14:0] int_acc    = '0;
   logic [16:0] frac_acc   = '0;
   logic [2:0]  frac_cnt   = '0;
   logic        point_seen = 1'b0;
   logic [14:0] lat_int    = '0;
   logic [16:0] lat_frac   = '0;
   logic        south      = 1'b0;
   logic        bad        = 1'b0;

   result_type  expected_positions[$];
   result_type  head_position;
   int          error_count = 0;

   function automatic int unsigned frac_scaled(input int unsigned f, input int unsigned n);
      while (n < FRAC_KEPT_MAX) begin
         f = f * 10;
         n++;
      end
      return f;
   endfunction

   function automatic bit in_range(input int unsigned ip, input int unsigned f5,
                                   input int unsigned max_deg);
      if (ip % 100 >= MINUTES_LIMIT) return 1'b0;
      if (ip / 100 < max_deg) return 1'b1;
      return (ip / 100 == max_deg) && (ip % 100 == 0) && (f5 == 0);
   endfunction

   task automatic split_axis(input int unsigned ip, input int unsigned f5,
                             input int unsigned max_deg,
                             output int unsigned deg, output int unsigned mins);
      deg  = ip / 100;
      mins = (ip % 100) * MIN_E5_UNIT + f5;
      if (deg > max_deg) deg = max_deg;
      if (mins > MIN_E5_MAX) mins = MIN_E5_MAX;
   endtask

   task automatic clear_parse_state();
      fld        = FIELD_LAT;
      int_acc    = '0;
      frac_acc   = '0;
      frac_cnt   = '0;
      point_seen = 1'b0;
      lat_int    = '0;
      lat_frac   = '0;
      south      = 1'b0;
      bad        = 1'b0;
   endtask

   task automatic take_number_char(input logic [7:0] b);
      int unsigned digit;
      int unsigned v;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         digit = b - CHAR_ZERO;
         if (!point_seen) begin
            v = int_acc * 10 + digit;
            if (v > INT_SAT) begin
               v   = INT_SAT;
               bad = 1'b1;
            end
            int_acc = v[14:0];
         end else if (frac_cnt < KEPT_DIGITS) begin
            // extra fraction digits fall off without error
            v        = frac_acc * 10 + digit;
            frac_acc = v[16:0];
            frac_cnt = frac_cnt + 3'd1;
         end
      end else if (b == CHAR_POINT) begin
         if (point_seen) bad = 1'b1;
         point_seen = 1'b1;
      end else begin
         bad = 1'b1;
      end
   endtask

   task automatic predict_gll_byte(input logic [7:0] b);
      result_type  pos;
      int unsigned f5;
      int unsigned deg;
      int unsigned mins;
      f5 = frac_scaled(frac_acc, frac_cnt);
      if (b == CHAR_DOLLAR) begin
         clear_parse_state();
         hdr_pos = 3'd1;
      end else if (hdr_pos == HDR_IDLE) begin
         // hunting for a dollar
      end else if (hdr_pos != HDR_BODY) begin
         if (b == GLL_TAIL[47 - 8 * (hdr_pos - 1) -: 8]) hdr_pos = hdr_pos + 3'd1;
         else hdr_pos = HDR_IDLE;
      end else begin
         case (fld)
            FIELD_LAT: begin
               if (b == CHAR_COMMA) begin
                  if (!in_range(int_acc, f5, LAT_MAX_DEG)) bad = 1'b1;
                  lat_int    = int_acc;
                  lat_frac   = f5[16:0];
                  int_acc    = '0;
                  frac_acc   = '0;
                  frac_cnt   = '0;
                  point_seen = 1'b0;
                  fld        = FIELD_NS;
               end else begin
                  take_number_char(b);
               end
            end
            FIELD_NS: begin
               // point_seen marks that a hemisphere letter arrived
               if (b == CHAR_N || b == CHAR_S) begin
                  if (point_seen) bad = 1'b1;
                  point_seen = 1'b1;
                  south      = (b == CHAR_S);
               end else if (b == CHAR_COMMA) begin
                  if (!point_seen) bad = 1'b1;
                  point_seen = 1'b0;
                  fld        = FIELD_LON;
               end else begin
                  bad = 1'b1;
               end
            end
            FIELD_LON: begin
               if (b == CHAR_COMMA) begin
                  if (!in_range(int_acc, f5, LON_MAX_DEG)) bad = 1'b1;
                  fld = FIELD_EW;
               end else begin
                  take_number_char(b);
               end
            end
            default: begin
               if (b == CHAR_E || b == CHAR_W) begin
                  split_axis(lat_int, lat_frac, LAT_MAX_DEG, deg, mins);
                  pos.lat_degrees    = deg[6:0];
                  pos.lat_minutes_e5 = mins[22:0];
                  pos.lat_south      = south;
                  split_axis(int_acc, f5, LON_MAX_DEG, deg, mins);
                  pos.lon_degrees    = deg[7:0];
                  pos.lon_minutes_e5 = mins[22:0];
                  pos.lon_west       = (b == CHAR_W);
                  pos.well_formed    = !bad;
                  expected_positions.push_back(pos);
                  hdr_pos = HDR_IDLE;
                  clear_parse_state();
               end else if (b == CHAR_COMMA) begin
                  // sentence dropped
                  hdr_pos = HDR_IDLE;
                  clear_parse_state();
               end else begin
                  bad = 1'b1;
               end
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // sentence building
   // ------------------------------------------------------------------------
   logic [7:0] pending_bytes[$];
   logic [7:0] sentence_buf[$];
   int         sentence_bytes = 0;

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) sentence_buf.push_back(s[i]);
   endtask

   task automatic add_digits(input int unsigned value, input int count);
      int unsigned scale;
      scale = 1;
      for (int i = 1; i < count; i++) scale = scale * 10;
      for (int i = 0; i < count; i++) begin
         sentence_buf.push_back(CHAR_ZERO + 8'((value / scale) % 10));
         scale = scale / 10;
      end
   endtask

   task automatic add_random_digits(input int count);
      for (int i = 0; i < count; i++) sentence_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_coordinate(input int deg_digits, input int unsigned max_deg);
      int mode;
      mode = $urandom_range(0, 15);
      case (mode)
         0: add_random_digits($urandom_range(0, 7));
         1: begin
            add_digits(max_deg, deg_digits);
            add_digits(0, 2);
         end
         2: add_digits($urandom_range(0, 10 ** (deg_digits + 2) - 1), deg_digits + 2);
         default: begin
            add_digits($urandom_range(0, max_deg), deg_digits);
            add_digits($urandom_range(0, 59), 2);
         end
      endcase
      if (mode != 3) begin
         add_text(".");
         if (mode == 4) add_text(".");
         if (mode == 1 && $urandom_range(0, 1) == 0) add_digits(0, $urandom_range(0, 7));
         else add_random_digits($urandom_range(0, 7));
      end
   endtask

   task automatic flush_sentence(input bit mangle);
      int pos;
      pos = $urandom_range(0, sentence_buf.size() - 1);
      if (mangle) begin
         case ($urandom_range(0, 4))
            0: sentence_buf[pos] = 8'($urandom_range(0, 255));
            1: sentence_buf.insert(pos, 8'($urandom_range(0, 255)));
            2: sentence_buf.delete(pos);
            3: while (sentence_buf.size() > pos) sentence_buf.delete(sentence_buf.size() - 1);
            default: sentence_buf.insert(pos, CHAR_DOLLAR);
         endcase
      end
      sentence_bytes += sentence_buf.size();
      while (sentence_buf.size() != 0) pending_bytes.push_back(sentence_buf.pop_front());
      // line noise between sentences
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_random_sentence();
      int kind;
      kind = $urandom_range(0, 99);
      add_text("$GPGLL,");
      add_coordinate(2, LAT_MAX_DEG);
      add_text(",");
      case ($urandom_range(0, 11))
         0: ;
         1: add_text("NS");
         2: add_text("X");
         default: sentence_buf.push_back($urandom_range(0, 1) ? CHAR_S : CHAR_N);
      endcase
      add_text(",");
      add_coordinate(3, LON_MAX_DEG);
      add_text(",");
      sentence_buf.push_back($urandom_range(0, 1) ? CHAR_W : CHAR_E);
      if ($urandom_range(0, 2) == 0) add_text(",123519.00,A*4F\015\012");
      flush_sentence(kind >= 75);
   endtask

   // ------------------------------------------------------------------------
   // request driver: bursts with random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         hdr_pos = HDR_IDLE;
         clear_parse_state();
      end else begin
         if (req_valid && !req_stall) predict_gll_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response stall pattern: calm, random, or long runs
   // ------------------------------------------------------------------------
   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 150);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= (stall_left % 32) < 20;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // position monitor
   // ------------------------------------------------------------------------
   task automatic report_error(input string msg);
      $display("%0t ns  mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_positions.size() == 0) begin
            report_error("position beat with no sentence pending");
         end else begin
            head_position = expected_positions.pop_front();
            compare_field("lat_degrees", rsp_lat_degrees, head_position.lat_degrees);
            compare_field("lat_minutes_e5", rsp_lat_minutes_e5, head_position.lat_minutes_e5);
            compare_field("lat_south", rsp_lat_south, head_position.lat_south);
            compare_field("lon_degrees", rsp_lon_degrees, head_position.lon_degrees);
            compare_field("lon_minutes_e5", rsp_lon_minutes_e5, head_position.lon_minutes_e5);
            compare_field("lon_west", rsp_lon_west, head_position.lon_west);
            compare_field("well_formed", rsp_well_formed, head_position.well_formed);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("nmea_gll_position_parser_tb: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      add_text("$GPGLL,9000.00000,S,18000.00000,W");
      flush_sentence(1'b0);
      add_text("$GPGLL,0000,N,00000,E");
      flush_sentence(1'b0);
      add_text("$GPGLL,4916.4512345,N,12311.12,W,225444,A");
      flush_sentence(1'b0);
      add_text("$GPGLL,9000.1,N,18000.00001,E");
      flush_sentence(1'b0);
      add_text("$GPGLL,6099.5,S,18100,W");
      flush_sentence(1'b0);
      add_text("$GPGLL,123456.7.8,N,,E");
      flush_sentence(1'b0);
      add_text("$GPGLL,12x4,NS,001?0,qE");
      flush_sentence(1'b0);
      add_text("$GPGLL,,,,W");
      flush_sentence(1'b0);
      add_text("$GPGLL,1,N,2,,E");
      flush_sentence(1'b0);
      add_text("$GPGXL,1,N,2,E");
      flush_sentence(1'b0);
      add_text("$GP$GPGLL,1,S,2,E");
      flush_sentence(1'b0);
      while (sentence_bytes < STIM_BYTES) add_random_sentence();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sampled away from the active edge
      while (pending_bytes.size() != 0 || req_valid) @(negedge clock);
      while (expected_positions.size() != 0) @(negedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("nmea_gll_position_parser_tb: clean");
      end else begin
         $display("nmea_gll_position_parser_tb: errors");
      end
      $finish;
   end

endmodule
